FILE: design/ft12_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft12_pkg
// Shared constants and types for the FT1.2 variable frame receiver.
// ----------------------------------------------------------------------------
package ft12_pkg;

    // Frame octets and control bits
    localparam logic [7:0] START_OCTET    = 8'h68;
    localparam logic [7:0] END_OCTET      = 8'h16;
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
    localparam int CTRL_PRM_BIT = 6;
    localparam int CTRL_FCB_BIT = 5;
    localparam int CTRL_FCV_BIT = 4;

    // Reset value of the link address register
    localparam logic [7:0] LINK_ADDR_RESET = 8'h01;

    // Error codes, lowest nonzero wins
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_BAD_END  = 3'd1;
    localparam logic [2:0] ERR_ADDR     = 3'd2;
    localparam logic [2:0] ERR_NOT_PRM  = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM = 3'd4;
    localparam logic [2:0] ERR_BAD_LEN  = 3'd5;

    // Completed frame as seen by the frame parser
    typedef struct packed {
        logic       done;
        logic [2:0] error_code;
        logic [7:0] control;
        logic [7:0] address;
        logic [7:0] length;
    } frame_info_t;

endpackage

FILE: design/ft12_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft12_byte_if / ft12_result_if
// Valid/ready channels for received octets and for frame results.
// ----------------------------------------------------------------------------
interface ft12_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ft12_result_if;
    logic       valid;
    logic       ready;
    logic       frame_ok;
    logic [2:0] error_code;
    logic [7:0] control_byte;
    logic [7:0] link_addr_seen;
    logic [7:0] frame_length;
    logic       fcb_accept;

    modport source (output valid, output frame_ok, output error_code,
                    output control_byte, output link_addr_seen,
                    output frame_length, output fcb_accept, input ready);
    modport sink   (input valid, input frame_ok, input error_code,
                    input control_byte, input link_addr_seen,
                    input frame_length, input fcb_accept, output ready);
endinterface

FILE: design/ft12_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft12_in_stage
// Input register: holds one received octet until the parser consumes it.
// ----------------------------------------------------------------------------
module ft12_in_stage
    import ft12_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_ready,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Free when empty or when the held octet is consumed this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

FILE: design/ft12_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft12_frame_fsm
// Frame parser: hunts for the start octet, tracks the length, sums control,
// address and user data, and grades the frame at the end octet (or at once for a length below two).
// ----------------------------------------------------------------------------
module ft12_frame_fsm
    import ft12_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  link_address,
    output frame_info_t info
);

    // Parser phases
    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_LEN    = 4'd1;
    localparam logic [3:0] PH_LEN2   = 4'd2;
    localparam logic [3:0] PH_START2 = 4'd3;
    localparam logic [3:0] PH_CTRL   = 4'd4;
    localparam logic [3:0] PH_ADDR   = 4'd5;
    localparam logic [3:0] PH_DATA   = 4'd6;
    localparam logic [3:0] PH_CSUM   = 4'd7;
    localparam logic [3:0] PH_END    = 4'd8;

    logic [3:0] phase_reg,   phase_next;
    logic [7:0] count_reg,   count_next;
    logic [7:0] length_reg,  length_next;
    logic [7:0] sum_reg,     sum_next;
    logic [7:0] control_reg, control_next;
    logic [7:0] address_reg, address_next;
    logic [7:0] csum_reg,    csum_next;
    logic [7:0] count_dec;
    logic [7:0] data_count;
    logic [7:0] sum_add;

    assign count_dec  = count_reg - 8'd1;
    assign data_count = length_reg - 8'd2;
    assign sum_add    = sum_reg + rx_byte;

    // Next state and frame grading for the octet in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        sum_next     = sum_reg;
        control_next = control_reg;
        address_next = address_reg;
        csum_next    = csum_reg;
        info.done       = 1'b0;
        info.error_code = ERR_OK;
        info.control    = control_reg;
        info.address    = address_reg;
        info.length     = length_reg;

        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == START_OCTET)
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                if (rx_byte < 8'd2)
                begin
                    // too short to hold control and address
                    info.done       = 1'b1;
                    info.error_code = ERR_BAD_LEN;
                    info.control    = 8'd0;
                    info.address    = 8'd0;
                    info.length     = rx_byte;
                    phase_next      = PH_HUNT;
                end
                else
                begin
                    phase_next = PH_LEN2;
                end
            end
            PH_LEN2:
            begin
                phase_next = PH_START2;
            end
            PH_START2:
            begin
                phase_next = PH_CTRL;
            end
            PH_CTRL:
            begin
                control_next = rx_byte;
                sum_next     = rx_byte;
                phase_next   = PH_ADDR;
            end
            PH_ADDR:
            begin
                address_next = rx_byte;
                sum_next     = sum_add;
                count_next   = data_count;
                phase_next   = (data_count == 8'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA:
            begin
                sum_next   = sum_add;
                count_next = count_dec;
                if (count_dec == 8'd0)
                begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                csum_next  = rx_byte;
                phase_next = PH_END;
            end
            PH_END:
            begin
                info.done = 1'b1;
                if (rx_byte != END_OCTET)
                begin
                    info.error_code = ERR_BAD_END;
                end
                else if (address_reg != BROADCAST_ADDR && address_reg != link_address)
                begin
                    info.error_code = ERR_ADDR;
                end
                else if (!control_reg[CTRL_PRM_BIT])
                begin
                    info.error_code = ERR_NOT_PRM;
                end
                else if (sum_reg != csum_reg)
                begin
                    info.error_code = ERR_CHECKSUM;
                end
                count_next = 8'd0;
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        // Nothing to report without an octet
        if (!fire)
        begin
            info.done = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            count_reg   <= 8'd0;
            length_reg  <= 8'd0;
            sum_reg     <= 8'd0;
            control_reg <= 8'd0;
            address_reg <= 8'd0;
            csum_reg    <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            sum_reg     <= sum_next;
            control_reg <= control_next;
            address_reg <= address_next;
            csum_reg    <= csum_next;
        end
    end

endmodule

FILE: design/ft12_fcb_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft12_fcb_check
// Frame count bit tracking: decides whether a valid frame is new or repeated.
// ----------------------------------------------------------------------------
module ft12_fcb_check
    import ft12_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_info_t info,
    output logic        fcb_accept
);

    logic known_reg,  known_next;
    logic stored_reg, stored_next;
    logic frame_good;
    logic fcb_bit;

    assign frame_good = info.done && (info.error_code == ERR_OK);
    assign fcb_bit    = info.control[CTRL_FCB_BIT];

    // Accept on first frame, on FCV clear, or on a toggled count bit
    always_comb
    begin
        known_next  = known_reg;
        stored_next = stored_reg;
        fcb_accept  = 1'b0;
        if (frame_good)
        begin
            if (!known_reg)
            begin
                known_next  = 1'b1;
                stored_next = fcb_bit;
                fcb_accept  = 1'b1;
            end
            else if (info.control[CTRL_FCV_BIT])
            begin
                if (fcb_bit != stored_reg)
                begin
                    stored_next = fcb_bit;
                    fcb_accept  = 1'b1;
                end
            end
            else
            begin
                fcb_accept = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg  <= 1'b0;
            stored_reg <= 1'b0;
        end
        else
        begin
            known_reg  <= known_next;
            stored_reg <= stored_next;
        end
    end

endmodule

FILE: design/ft12_frame_receiver_fcb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft12_frame_receiver_fcb_unit
// FT1.2 variable frame receiver with frame count bit check.
// ----------------------------------------------------------------------------
// Takes one received octet per cycle on rx while not stalled. Each octet is
// held in an input register, then the parser updates its state and, when a
// frame ends (end octet, or a length below two), a result is written to the
// output register on res. Throughput is one octet per cycle as long as res
// drains; the input side stalls only when a result waits in the output
// register and the next octet is also waiting to be processed. The user
// must write link_address with cfg_we only while no frame is in flight; the
// block does not enforce this. Reset value is 1, and 0xFF is always accepted.
module ft12_frame_receiver_fcb_unit
    import ft12_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ft12_byte_if.sink            rx,
    ft12_result_if.source        res,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata
);

    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        fire;
    logic        fcb_accept;
    frame_info_t info;

    logic [7:0]  link_addr_reg;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  err_reg;
    logic [7:0]  ctrl_reg;
    logic [7:0]  addr_reg;
    logic [7:0]  len_reg;
    logic        acc_reg;

    // Process the held octet when the output register can take a result
    assign fire = byte_valid && (!out_valid_reg || res.ready);

    ft12_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_byte    (rx.rx_byte),
        .in_ready   (rx.ready),
        .advance    (fire),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ft12_frame_fsm u_frame_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .rx_byte      (byte_data),
        .link_address (link_addr_reg),
        .info         (info)
    );

    ft12_fcb_check u_fcb_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .info       (info),
        .fcb_accept (fcb_accept)
    );

    // Link address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_addr_reg <= LINK_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            link_addr_reg <= cfg_wdata;
        end
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = info.done;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (fire && info.done)
        begin
            err_reg  <= info.error_code;
            ctrl_reg <= info.control;
            addr_reg <= info.address;
            len_reg  <= info.length;
            acc_reg  <= fcb_accept;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.frame_ok       = (err_reg == ERR_OK);
    assign res.error_code     = err_reg;
    assign res.control_byte   = ctrl_reg;
    assign res.link_addr_seen = addr_reg;
    assign res.frame_length   = len_reg;
    assign res.fcb_accept     = acc_reg;

    // A new frame is only accepted by the count bit rule if it passed checks
    a_accept_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!res.fcb_accept || res.error_code == ERR_OK))
        else $error("fcb_accept set on a failed frame");

    // Length errors only for lengths below two, with cleared control/address
    a_bad_len_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.error_code == ERR_BAD_LEN) |->
        (res.frame_length < 8'd2 && res.control_byte == 8'd0
         && res.link_addr_seen == 8'd0))
        else $error("bad length result with unexpected fields");

    // Input stalls only while an octet waits behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> (byte_valid && out_valid_reg && !res.ready))
        else $error("input stalled without a pending result");

    // A result held under backpressure is not replaced
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> (out_valid_reg && $stable(err_reg)
         && $stable(len_reg)))
        else $error("pending result changed while stalled");

endmodule
